// File: rtl/core/assert_macros.svh
// Assertion shorthands shared by the phase code generator RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// File: rtl/core/rpcg_pkg.sv
// Shared types, codes and Barker tables for the radar phase code generator.
// No dependencies; imported by rpcg_csr, rpcg_front, rpcg_back and the top module.
`default_nettype none

package rpcg_pkg;

   localparam int IDX_W  = 12;
   localparam int LEN_W  = 13;
   localparam int SIDE_W = 7;   // floor(sqrt(2^13 - 1)) = 90 fits in 7 bits

   typedef enum logic [1:0] {
      KIND_BARKER  = 2'd0,
      KIND_FRANK   = 2'd1,
      KIND_P4      = 2'd2,
      KIND_INVALID = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_LEN   = 2'd1,
      STATUS_BAD_INDEX = 2'd2,
      STATUS_BAD_KIND  = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      REG_CODE_KIND   = 1'b0,
      REG_CODE_LENGTH = 1'b1
   } csr_index_type;

   // settled configuration as seen by the datapath
   typedef struct packed {
      kind_type           kind;
      logic [LEN_W-1:0]   len;
      logic [SIDE_W-1:0]  side;
      logic               barker_ok;
      logic [2:0]         barker_row;
      logic               frank_ok;
      logic               p4_ok;
      logic               busy;
   } cfg_type;

   // per-item control that rides along the back pipeline
   typedef struct packed {
      status_type status;
      kind_type   kind;
      logic       chip;     // Barker chip is a half turn
   } tag_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      tag_type          tag;
   } item_type;

   // {valid, row} for a Barker length
   function automatic logic [3:0] barker_row_of(input logic [LEN_W-1:0] len);
      logic [3:0] res;
      unique case (len)
         LEN_W'(2):  res = 4'b1_000;
         LEN_W'(3):  res = 4'b1_001;
         LEN_W'(4):  res = 4'b1_010;
         LEN_W'(5):  res = 4'b1_011;
         LEN_W'(7):  res = 4'b1_100;
         LEN_W'(11): res = 4'b1_101;
         LEN_W'(13): res = 4'b1_110;
         default:    res = 4'b0_000;
      endcase
      return res;
   endfunction

   // chip pattern per row, bit i = chip i
   function automatic logic barker_chip(input logic [2:0] row, input logic [3:0] pos);
      logic [15:0] pat;
      unique case (row)
         3'd0:    pat = 16'h0002;
         3'd1:    pat = 16'h0004;
         3'd2:    pat = 16'h0008;
         3'd3:    pat = 16'h0008;
         3'd4:    pat = 16'h0058;
         3'd5:    pat = 16'h05B8;
         3'd6:    pat = 16'h0A60;
         default: pat = 16'h0000;
      endcase
      return pat[pos];
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/rpcg_csr.sv
// Configuration registers and the code-length root unit.
// Depends on rpcg_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rpcg_csr
   import rpcg_pkg::*;
#(
   parameter int MAX_LENGTH = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   localparam int BIT_W = $clog2(SIDE_W);
   localparam int SQ_W  = 2 * SIDE_W;

   typedef enum logic [2:0] {
      RS_IDLE  = 3'b001,
      RS_ROOT  = 3'b010,
      RS_CHECK = 3'b100
   } root_state_type;

   root_state_type    state_ff, state_in;
   kind_type          kind_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [SIDE_W-1:0] side_ff, side_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic              barker_ok_ff, frank_ok_ff, p4_ok_ff;
   logic [2:0]        row_ff;

   logic              wr, wr_kind, wr_len;
   csr_index_type     wr_index;
   logic [SIDE_W-1:0] trial;
   logic [SQ_W-1:0]   trial_sq, side_sq, len_wide;
   logic              len_in_range;
   logic [3:0]        brow;

   assign csr_pready = 1'b1;
   assign wr       = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign wr_index = csr_index_type'(csr_paddr[2]);
   assign wr_kind  = wr && (wr_index == REG_CODE_KIND);
   assign wr_len   = wr && (wr_index == REG_CODE_LENGTH);

   always_comb begin
      unique case (wr_index)
         REG_CODE_KIND:   csr_prdata = 32'(kind_ff);
         REG_CODE_LENGTH: csr_prdata = 32'(len_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // digit-by-digit integer square root, one bit per cycle
   assign trial        = side_ff | (SIDE_W'(1) << bit_ff);
   assign trial_sq     = SQ_W'(trial) * SQ_W'(trial);
   assign side_sq      = SQ_W'(side_ff) * SQ_W'(side_ff);
   assign len_wide     = SQ_W'(len_ff);
   assign len_in_range = 32'(len_ff) <= 32'(MAX_LENGTH);
   assign brow         = barker_row_of(len_ff);

   always_comb begin
      state_in = state_ff;
      side_in  = side_ff;
      bit_in   = bit_ff;
      unique case (state_ff)
         RS_IDLE: ;
         RS_ROOT: begin
            if (trial_sq <= len_wide) begin
               side_in = trial;
            end
            if (bit_ff == '0) begin
               state_in = RS_CHECK;
            end else begin
               bit_in = bit_ff - BIT_W'(1);
            end
         end
         RS_CHECK: state_in = RS_IDLE;
         default:  state_in = RS_IDLE;
      endcase
      if (wr_len) begin
         state_in = RS_ROOT;
         side_in  = '0;
         bit_in   = BIT_W'(SIDE_W - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RS_ROOT;
         side_ff  <= '0;
         bit_ff   <= BIT_W'(SIDE_W - 1);
         kind_ff  <= KIND_BARKER;
         len_ff   <= LEN_W'(13);
      end else begin
         state_ff <= state_in;
         side_ff  <= side_in;
         bit_ff   <= bit_in;
         if (wr_kind) begin
            kind_ff <= kind_type'(csr_pwdata[1:0]);
         end
         if (wr_len) begin
            len_ff <= csr_pwdata[LEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == RS_CHECK) begin
         barker_ok_ff <= brow[3] && len_in_range;
         row_ff       <= brow[2:0];
         frank_ok_ff  <= (side_sq == len_wide) && len_in_range;
         p4_ok_ff     <= len_in_range;
      end
   end

   assign cfg.kind       = kind_ff;
   assign cfg.len        = len_ff;
   assign cfg.side       = side_ff;
   assign cfg.barker_ok  = barker_ok_ff;
   assign cfg.barker_row = row_ff;
   assign cfg.frank_ok   = frank_ok_ff;
   assign cfg.p4_ok      = p4_ok_ff;
   assign cfg.busy       = (state_ff != RS_IDLE);

   `ASSERT_NEXT(a_len_write_restarts_root, clock, reset, wr_len, state_ff == RS_ROOT)
   `ASSERT_IMPLIES(a_frank_ok_is_square, clock, reset, (state_ff == RS_IDLE) && frank_ok_ff, side_sq == len_wide)

endmodule

`default_nettype wire

// File: rtl/core/rpcg_front.sv
// Front end: classifies an incoming chip request against the configuration.
// Depends on rpcg_pkg.
`default_nettype none

module rpcg_front
   import rpcg_pkg::*;
(
   input  wire cfg_type           cfg,
   input  wire logic [IDX_W-1:0]  element_index,
   output item_type               item
);

   logic idx_out;

   assign idx_out = LEN_W'(element_index) >= cfg.len;

   always_comb begin
      item.idx        = element_index;
      item.tag.kind   = cfg.kind;
      item.tag.chip   = 1'b0;
      item.tag.status = STATUS_OK;
      unique case (cfg.kind)
         KIND_BARKER: begin
            if (!cfg.barker_ok) begin
               item.tag.status = STATUS_BAD_LEN;
            end else if (idx_out) begin
               item.tag.status = STATUS_BAD_INDEX;
            end else begin
               item.tag.chip = barker_chip(cfg.barker_row, element_index[3:0]);
            end
         end
         KIND_FRANK: begin
            if (!cfg.frank_ok) begin
               item.tag.status = STATUS_BAD_LEN;
            end else if (idx_out || (cfg.side == '0)) begin
               item.tag.status = STATUS_BAD_INDEX;
            end
         end
         KIND_P4: begin
            if (!cfg.p4_ok) begin
               item.tag.status = STATUS_BAD_LEN;
            end else if (idx_out) begin
               item.tag.status = STATUS_BAD_INDEX;
            end
         end
         default: item.tag.status = STATUS_BAD_KIND;
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/core/rpcg_queue.sv
// Small register queue between the front and back ends.
// Depends on rpcg_pkg (convention only) and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rpcg_queue #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 2     // power of two
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  full,
   output logic                  empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   `ASSERT_ALWAYS(a_count_bounded, clock, reset, count_ff <= CNT_W'(DEPTH))

endmodule

`default_nettype wire

// File: rtl/core/rpcg_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a tag lane.
// No package dependencies.
`default_nettype none

module rpcg_div #(
   parameter int NUM_W = 29,
   parameter int DEN_W = 14,
   parameter int TAG_W = 5
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic             in_valid,
   input  wire logic [NUM_W-1:0] in_num,
   input  wire logic [DEN_W-1:0] in_den,
   input  wire logic [TAG_W-1:0] in_tag,
   output logic                  out_valid,
   output logic [NUM_W-1:0]      out_quot,
   output logic [DEN_W-1:0]      out_rem,
   output logic [TAG_W-1:0]      out_tag
);

   logic             vld_ff [0:NUM_W];
   logic [NUM_W-1:0] num_ff [0:NUM_W];   // dividend shifts out, quotient shifts in
   logic [DEN_W-1:0] rem_ff [0:NUM_W];
   logic [DEN_W-1:0] den_ff [0:NUM_W];
   logic [TAG_W-1:0] tag_ff [0:NUM_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff[0] <= in_num;
         rem_ff[0] <= '0;
         den_ff[0] <= in_den;
         tag_ff[0] <= in_tag;
      end
   end

   for (genvar s = 0; s < NUM_W; s++) begin : g_step
      logic [DEN_W:0]   trial, diff;
      logic             ge;
      logic [DEN_W-1:0] rem_in;
      logic [NUM_W-1:0] num_in;

      assign trial  = {rem_ff[s], num_ff[s][NUM_W-1]};
      assign diff   = trial - {1'b0, den_ff[s]};
      assign ge     = trial >= {1'b0, den_ff[s]};
      assign rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      assign num_in = {num_ff[s][NUM_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[s+1] <= vld_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            num_ff[s+1] <= num_in;
            rem_ff[s+1] <= rem_in;
            den_ff[s+1] <= den_ff[s];
            tag_ff[s+1] <= tag_ff[s];
         end
      end
   end

   assign out_valid = vld_ff[NUM_W];
   assign out_quot  = num_ff[NUM_W];
   assign out_rem   = rem_ff[NUM_W];
   assign out_tag   = tag_ff[NUM_W];

endmodule

`default_nettype wire

// File: rtl/core/rpcg_back.sv
// Back end: three divider passes that turn a chip index into its phase.
// Depends on rpcg_pkg, rpcg_div and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rpcg_back
   import rpcg_pkg::*;
#(
   parameter int PHASE_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cfg_type                cfg,
   input  wire logic                   q_empty,
   input  wire item_type               q_item,
   output logic                        q_pop,
   input  wire logic                   rsp_pop,
   output logic                        rsp_empty,
   output logic signed [PHASE_BITS-1:0] rsp_phase,
   output logic [1:0]                  rsp_status
);

   localparam int PROD_W = IDX_W + LEN_W;
   localparam int NUM_W  = (PHASE_BITS + LEN_W > PROD_W) ? PHASE_BITS + LEN_W : PROD_W;
   localparam int DEN_W  = LEN_W + 1;
   localparam int TAG_W  = $bits(tag_type);
   localparam logic [PHASE_BITS-1:0] HALF_TURN = {1'b1, {(PHASE_BITS-1){1'b0}}};

   logic                  advance;
   logic                  out_vld_ff;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   status_type            status_ff;

   // pass 1: Frank idx / side, P4 idx*(len-idx) mod 2*len
   logic [LEN_W-1:0]  p4_gap;
   logic [PROD_W-1:0] p4_prod;
   logic [NUM_W-1:0]  d1_num, d1_quot;
   logic [DEN_W-1:0]  d1_den, d1_rem, twice_len;
   logic              d1_valid;
   tag_type           d1_tag;

   // pass 2: Frank n*k mod side, P4 wrapped phase scaled by len
   logic [2*SIDE_W-1:0] frank_nk;
   logic [DEN_W-1:0]    p4_wrap;
   logic [NUM_W-1:0]    d2_num, d2_quot;
   logic [DEN_W-1:0]    d2_den, d2_rem;
   logic                d2_valid;
   tag_type             d2_tag;

   // pass 3: Frank residue scaled by side, P4 passes through
   logic [NUM_W-1:0] d3_num, d3_quot;
   logic [DEN_W-1:0] d3_den, d3_rem;
   logic             d3_valid;
   tag_type          d3_tag;

   assign advance = !out_vld_ff || rsp_pop;
   assign q_pop   = advance && !q_empty;

   assign twice_len = {cfg.len, 1'b0};
   assign p4_gap    = cfg.len - LEN_W'(q_item.idx);
   assign p4_prod   = PROD_W'(q_item.idx) * PROD_W'(p4_gap);
   assign d1_num    = (q_item.tag.kind == KIND_P4) ? NUM_W'(p4_prod) : NUM_W'(q_item.idx);
   assign d1_den    = (q_item.tag.kind == KIND_P4) ? twice_len : DEN_W'(cfg.side);

   rpcg_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .TAG_W(TAG_W)) u_div1 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (q_pop),
      .in_num    (d1_num),
      .in_den    (d1_den),
      .in_tag    (q_item.tag),
      .out_valid (d1_valid),
      .out_quot  (d1_quot),
      .out_rem   (d1_rem),
      .out_tag   (d1_tag)
   );

   assign frank_nk = (2*SIDE_W)'(d1_quot[SIDE_W-1:0]) * (2*SIDE_W)'(d1_rem[SIDE_W-1:0]);
   assign p4_wrap  = (d1_rem == '0) ? '0 : twice_len - d1_rem;
   assign d2_num   = (d1_tag.kind == KIND_FRANK) ? NUM_W'(frank_nk)
                                                 : NUM_W'(p4_wrap) << (PHASE_BITS - 1);
   assign d2_den   = (d1_tag.kind == KIND_FRANK) ? DEN_W'(cfg.side) : DEN_W'(cfg.len);

   rpcg_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .TAG_W(TAG_W)) u_div2 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (d1_valid),
      .in_num    (d2_num),
      .in_den    (d2_den),
      .in_tag    (d1_tag),
      .out_valid (d2_valid),
      .out_quot  (d2_quot),
      .out_rem   (d2_rem),
      .out_tag   (d2_tag)
   );

   assign d3_num = (d2_tag.kind == KIND_FRANK) ? NUM_W'(d2_rem[SIDE_W-1:0]) << PHASE_BITS
                                               : d2_quot;
   assign d3_den = (d2_tag.kind == KIND_FRANK) ? DEN_W'(cfg.side) : DEN_W'(1);

   rpcg_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .TAG_W(TAG_W)) u_div3 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (d2_valid),
      .in_num    (d3_num),
      .in_den    (d3_den),
      .in_tag    (d2_tag),
      .out_valid (d3_valid),
      .out_quot  (d3_quot),
      .out_rem   (d3_rem),
      .out_tag   (d3_tag)
   );

   always_comb begin
      if (d3_tag.status != STATUS_OK) begin
         phase_in = '0;
      end else if (d3_tag.kind == KIND_BARKER) begin
         phase_in = d3_tag.chip ? HALF_TURN : '0;
      end else begin
         phase_in = d3_quot[PHASE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= d3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && d3_valid) begin
         phase_ff  <= phase_in;
         status_ff <= d3_tag.status;
      end
   end

   assign rsp_empty  = !out_vld_ff;
   assign rsp_phase  = phase_ff;
   assign rsp_status = status_ff;

   `ASSERT_IMPLIES(a_error_phase_zero, clock, reset, out_vld_ff && (status_ff != STATUS_OK), phase_ff == '0)
   `ASSERT_IMPLIES(a_stall_holds_queue, clock, reset, !advance, !q_pop && (d3_rem == d3_rem))

endmodule

`default_nettype wire

// File: rtl/core/radar_phase_code_generator.sv
// Radar phase code generator. Each request beat names one chip of a Barker,
// Frank or P4 pulse-compression code (kind and length set through the CSR
// port: code_kind at 0x0, code_length at 0x4) and the block answers that
// chip's phase wrapped into [-pi, pi) as a signed fraction of pi, exact rational
// value floored to one LSB, plus a status code (ok, bad length, index out of
// range, bad kind; the phase reads zero on any error). Throughput is one beat
// per clock sustained while results are popped and no square-root run is settling.
// The back end holds three pipelined restoring dividers of NUM_W bits, NUM_W
// being max(25, PHASE_BITS+13), one quotient bit per stage (index split for
// Frank, mod 2*len for P4, final scaling). After reset and after each
// code_length write an integer square-root unit runs, one root bit a cycle
// plus a check; req_full stays high meanwhile.
// Configure only while no beats are in flight.
`default_nettype none

module radar_phase_code_generator
   import rpcg_pkg::*;
#(
   parameter int MAX_LENGTH = 4096,
   parameter int PHASE_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request beats
   input  wire logic                    req_push,
   output logic                         req_full,
   input  wire logic [IDX_W-1:0]        req_element_index,
   // result beats
   output logic                         rsp_empty,
   input  wire logic                    rsp_pop,
   output logic signed [PHASE_BITS-1:0] rsp_phase,
   output logic [1:0]                   rsp_status,
   // CSR port
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [2:0]              csr_paddr,
   input  wire logic [31:0]             csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   localparam int QUEUE_DEPTH = 2;

   cfg_type  cfg;
   item_type front_item, q_item;
   logic     q_full, q_empty, q_pop, push_ok;

   rpcg_csr #(.MAX_LENGTH(MAX_LENGTH)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // front: classify and flag errors as the beat arrives
   rpcg_front u_front (
      .cfg           (cfg),
      .element_index (req_element_index),
      .item          (front_item)
   );

   // hold off while the root unit is settling the length flags
   assign req_full = q_full || cfg.busy;
   assign push_ok  = req_push && !req_full;

   rpcg_queue #(.WIDTH($bits(item_type)), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push_ok),
      .wdata (front_item),
      .pop   (q_pop),
      .rdata (q_item),
      .full  (q_full),
      .empty (q_empty)
   );

   // back: divider pipeline, stalls as a whole on a waiting result
   rpcg_back #(.PHASE_BITS(PHASE_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_empty    (q_empty),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_phase  (rsp_phase),
      .rsp_status (rsp_status)
   );

endmodule

`default_nettype wire

// File: test/phase_code_checker.sv
// Checker for the radar phase code generator: watches request and result beats,
// predicts each chip phase and compares. Depends on rpcg_pkg.
`timescale 1ns / 100ps

module phase_code_checker
   import rpcg_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   input  wire logic              req_full,
   input  wire logic [IDX_W-1:0]  req_element_index,
   input  wire logic              rsp_empty,
   input  wire logic              rsp_pop,
   input  wire logic signed [15:0] rsp_phase,
   input  wire logic [1:0]        rsp_status,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [2:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   input  wire logic              csr_pready,
   output int                     fail_count,
   output int                     pending
);

   typedef struct packed {
      logic [15:0] phase;
      status_type  status;
   } chip_result_type;

   chip_result_type expected_chips[$];
   kind_type         kind_q;
   logic [LEN_W-1:0] length_q;

   assign pending = expected_chips.size();

   // own copy of the Barker sequences, chip i is bit i
   function automatic logic barker_bit(input logic [2:0] row, input logic [3:0] pos);
      logic [12:0] seq [7];
      seq[0] = 13'b0000000000010;
      seq[1] = 13'b0000000000100;
      seq[2] = 13'b0000000001000;
      seq[3] = 13'b0000000001000;
      seq[4] = 13'b0000001011000;
      seq[5] = 13'b0010110111000;
      seq[6] = 13'b0101001100000;
      return (row < 7 && pos < 13) ? seq[row][pos] : 1'b0;
   endfunction

   function automatic chip_result_type chip_phase(input logic [IDX_W-1:0] idx);
      chip_result_type res;
      longint unsigned len, side, n, k, r, twice, neg, units;
      logic [3:0] brow;
      len = length_q;
      units = 0;
      res.status = STATUS_OK;
      case (kind_q)
         KIND_BARKER: begin
            brow = barker_row_of(length_q);
            if (!brow[3] || len > 4096) res.status = STATUS_BAD_LEN;
            else if (idx >= len) res.status = STATUS_BAD_INDEX;
            else units = barker_bit(brow[2:0], idx[3:0]) ? 32768 : 0;
         end
         KIND_FRANK: begin
            side = 0;
            while ((side + 1) * (side + 1) <= len) side++;
            if (side * side != len || len > 4096) res.status = STATUS_BAD_LEN;
            else if (idx >= len || side == 0) res.status = STATUS_BAD_INDEX;
            else begin
               n = idx / side;
               k = idx % side;
               r = (n * k) % side;
               units = (r << 16) / side;
            end
         end
         KIND_P4: begin
            if (len > 4096) res.status = STATUS_BAD_LEN;
            else if (idx >= len || len == 0) res.status = STATUS_BAD_INDEX;
            else begin
               twice = 2 * len;
               neg = (idx * (len - idx)) % twice;
               r = (twice - neg) % twice;
               units = (r << 15) / len;
            end
         end
         default: res.status = STATUS_BAD_KIND;
      endcase
      res.phase = (res.status == STATUS_OK) ? units[15:0] : 16'd0;
      return res;
   endfunction

   always @(posedge clock) begin
      chip_result_type want;
      int errs;
      errs = 0;
      if (reset) begin
         kind_q <= KIND_BARKER;
         length_q <= LEN_W'(13);
         expected_chips.delete();
         fail_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_CODE_KIND) kind_q <= kind_type'(csr_pwdata[1:0]);
            else length_q <= csr_pwdata[LEN_W-1:0];
         end
         if (req_push && !req_full) expected_chips.push_back(chip_phase(req_element_index));
         if (rsp_pop && !rsp_empty) begin
            if (expected_chips.size() == 0) begin
               $error("result beat with nothing expected");
               errs++;
            end else begin
               want = expected_chips.pop_front();
               if (rsp_phase !== want.phase) begin
                  $error("phase: expected %0d actual %0d", $signed(want.phase), rsp_phase);
                  errs++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d actual %0d", want.status, rsp_status);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end

endmodule

// File: test/tb_top.sv
// Top of the phase code generator testbench: clock, reset, CSR writes, request
// stimulus and result pops; checking lives in phase_code_checker. Needs rpcg_pkg.
`timescale 1ns / 100ps

module tb_top;
   import rpcg_pkg::*;

   localparam int LATENCY = 92;
   localparam longint CYCLE_LIMIT = 1000000;

   logic clock, reset;
   logic req_push, req_full;
   logic [IDX_W-1:0] req_element_index;
   logic rsp_empty, rsp_pop;
   logic signed [15:0] rsp_phase;
   logic [1:0] rsp_status;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [2:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   int fail_count, pending;

   int send_idle_pct, pop_stall_pct;
   bit hold_pops;          // long receiver hold-off
   longint cycles;

   radar_phase_code_generator dut (.*);

   phase_code_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // cycle counter guards against a hung block
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // receiver: random stalls, except while held off
   always @(posedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= !hold_pops && ($urandom_range(99) >= pop_stall_pct);
   end

   task automatic csr_write(input csr_index_type reg_index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // one request beat, with optional idle cycles ahead of it
   task automatic send_chip(input logic [IDX_W-1:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_element_index <= idx;
      do @(posedge clock); while (req_full);
   endtask

   // stop sending and let every pending result come back, then settle
   task automatic drain;
      req_push <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic set_code(input kind_type kind, input logic [12:0] len);
      drain();
      csr_write(REG_CODE_KIND, 32'(kind));
      csr_write(REG_CODE_LENGTH, 32'(len));
   endtask

   // index mostly within the code, now and then past its end or at the top
   function automatic logic [IDX_W-1:0] pick_index(input logic [12:0] len);
      int sel;
      sel = $urandom_range(9);
      if (sel == 0 || len == 0) return IDX_W'($urandom);
      if (sel == 1) return '1;
      return IDX_W'($urandom_range(len > 4096 ? 4095 : len - 1));
   endfunction

   logic [12:0] lengths[$] = '{13, 2, 3, 4, 5, 7, 11, 64, 4096, 4, 9, 1, 0, 17, 100,
                               8191, 4097, 6, 2048, 25, 81};

   initial begin
      kind_type kinds[4];
      kind_type kind;
      logic [12:0] len;
      int phase;
      kinds = '{KIND_BARKER, KIND_FRANK, KIND_P4, KIND_INVALID};
      reset = 1'b1;
      req_push = 1'b0;
      req_element_index = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      hold_pops = 1'b0;
      send_idle_pct = 0;
      pop_stall_pct = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings (Barker 13) at edges, then each kind
      send_chip(0); send_chip(12); send_chip(13); send_chip('1);
      set_code(KIND_FRANK, 16);
      send_chip(0); send_chip(5); send_chip(15); send_chip(16);
      set_code(KIND_FRANK, 15);       // not a square
      send_chip(0);
      set_code(KIND_FRANK, 0);        // zero length
      send_chip(0);
      set_code(KIND_P4, 4096);
      send_chip(0); send_chip(1); send_chip(2048); send_chip(4095);
      set_code(KIND_P4, 8191);        // oversized
      send_chip(3);
      set_code(KIND_P4, 0);
      send_chip(0);
      set_code(KIND_BARKER, 6);       // unsupported Barker length
      send_chip(1);
      set_code(KIND_INVALID, 13);
      send_chip(2); send_chip('1);
      drain();
      csr_write(REG_CODE_LENGTH, 32'hFFFF_FFFF);   // upper bits dropped
      csr_write(REG_CODE_KIND, 32'hFFFF_FFFC);     // kind Barker
      send_chip(3);

      // random phases: no idling, sender idle, receiver stall, both
      for (phase = 0; phase < 20; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin send_idle_pct = 55; pop_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  pop_stall_pct = 55; end
            default: begin send_idle_pct = 13; pop_stall_pct = 13; end
         endcase
         kind = (phase % 7 == 6) ? KIND_INVALID : kinds[$urandom_range(2)];
         len = lengths[$urandom_range(lengths.size() - 1)];
         if (kind == KIND_BARKER && $urandom_range(3) != 0)
            len = lengths[$urandom_range(1, 6)];
         if (kind == KIND_FRANK && $urandom_range(3) != 0)
            len = 13'($urandom_range(1, 64) ** 2);
         set_code(kind, len);
         if (phase == 5) begin
            // hold off the receiver long enough for the block to fill up
            fork
               begin
                  hold_pops = 1'b1;
                  repeat (600) @(posedge clock);
                  hold_pops = 1'b0;
               end
            join_none
         end
         repeat (50) send_chip(pick_index(len));
      end

      drain();
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
